>>> src/pbd_pkg.sv
// Shared constants, types and round functions for the PRESENT-64 block decryptor.
package pbd_pkg;

    localparam int KEY_SLOTS   = 32;
    localparam int BLOCK_W     = 64;
    localparam int SLOT_W      = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        ACT_LOAD_KEY = 1'b0,
        ACT_DECRYPT  = 1'b1
    } pbd_action_t;

    typedef struct packed
    {
        pbd_action_t        action;
        logic [SLOT_W-1:0]  slot;
        logic [BLOCK_W-1:0] data;   // round key or ciphertext, by action
    } pbd_item_t;

    typedef struct packed
    {
        logic busy;
        logic pop;
    } pbd_status_t;

    function automatic logic [3:0] inv_sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'h5;
            4'h1: y = 4'hE;
            4'h2: y = 4'hF;
            4'h3: y = 4'h8;
            4'h4: y = 4'hC;
            4'h5: y = 4'h1;
            4'h6: y = 4'h2;
            4'h7: y = 4'hD;
            4'h8: y = 4'hB;
            4'h9: y = 4'h4;
            4'hA: y = 4'h6;
            4'hB: y = 4'h3;
            4'hC: y = 4'h0;
            4'hD: y = 4'h7;
            4'hE: y = 4'h9;
            4'hF: y = 4'hA;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    // Output bit 4q+m takes input bit q+16m.
    function automatic logic [BLOCK_W-1:0] inv_perm(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int q = 0; q < 16; q++)
        begin
            for (int m = 0; m < 4; m++)
            begin
                r[4*q+m] = s[q+16*m];
            end
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] inv_sbox_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int n = 0; n < 16; n++)
        begin
            r[4*n +: 4] = inv_sbox(s[4*n +: 4]);
        end
        return r;
    endfunction

endpackage

>>> src/present_block_decrypt.sv
// Top level of the PRESENT-64 block decryptor with a loaded round key schedule.
// Requests enter a two-deep queue; a key load (action 0) writes one of the 32
// round keys into the key RAM, with no response. A decrypt (action 1) fetches
// round key 31 from the single read port of the key RAM, runs 31 inverse rounds
// at one per cycle, and ends with the final XOR with round key 0. All 32 round
// keys must be loaded before the first decrypt. The response sits in an output
// register, so the engine starts on the next queued request while the result
// waits to be taken.
module present_block_decrypt
#(
    parameter int KEY_SLOTS = pbd_pkg::KEY_SLOTS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic                        action,
    input  logic [pbd_pkg::SLOT_W-1:0]  key_slot,
    input  logic [pbd_pkg::BLOCK_W-1:0] key_word,
    input  logic [pbd_pkg::BLOCK_W-1:0] cipher_block,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [pbd_pkg::BLOCK_W-1:0] plain_block
);
    import pbd_pkg::*;

    logic        q_valid;
    pbd_item_t   q_item;
    pbd_status_t status;

    pbd_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .action       (action),
        .key_slot     (key_slot),
        .key_word     (key_word),
        .cipher_block (cipher_block),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (status.pop)
    );

    pbd_back
    #(
        .KEY_SLOTS (KEY_SLOTS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .status      (status),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .plain_block (plain_block)
    );

`ifndef NO_ASSERTIONS
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        status.pop |-> q_valid)
        else $error("queue popped while empty");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !status.pop)
        else $error("queue popped during a decrypt");

    a_result_from_engine: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(status.busy))
        else $error("response raised without a decrypt in flight");

    a_decrypt_starts_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (status.pop && q_item.action == ACT_DECRYPT) |=> status.busy)
        else $error("decrypt popped but engine did not start");
`endif

endmodule

>>> src/pbd_front.sv
// Request intake: classifies each request and queues it for the round engine.
module pbd_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic                        action,
    input  logic [pbd_pkg::SLOT_W-1:0]  key_slot,
    input  logic [pbd_pkg::BLOCK_W-1:0] key_word,
    input  logic [pbd_pkg::BLOCK_W-1:0] cipher_block,
    output logic                        q_valid,
    output pbd_pkg::pbd_item_t          q_item,
    input  logic                        q_pop
);
    import pbd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pbd_item_t          queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    pbd_item_t          new_item;

    assign req_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push      = req_valid && req_ready;
    assign q_valid   = (count_reg != '0);
    assign q_item    = queue_mem[rd_ptr_reg];

    always_comb
    begin
        new_item.action = pbd_action_t'(action);
        new_item.slot   = key_slot;
        new_item.data   = (pbd_action_t'(action) == ACT_DECRYPT) ? cipher_block : key_word;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

>>> src/pbd_back.sv
// Round engine: round key RAM and one inverse PRESENT round per cycle.
module pbd_back
#(
    parameter int KEY_SLOTS = pbd_pkg::KEY_SLOTS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  pbd_pkg::pbd_item_t          q_item,
    output pbd_pkg::pbd_status_t        status,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [pbd_pkg::BLOCK_W-1:0] plain_block
);
    import pbd_pkg::*;

    localparam int AW = $clog2(KEY_SLOTS);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } pbd_state_t;

    pbd_state_t         state_reg, state_next;
    logic [AW-1:0]      round_reg, round_next;
    logic [BLOCK_W-1:0] blk_reg, blk_next;
    logic [BLOCK_W-1:0] plain_reg, plain_next;
    logic               res_valid_reg, res_valid_next;
    logic [BLOCK_W-1:0] key_mem [KEY_SLOTS];
    logic [BLOCK_W-1:0] key_rd;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic               pop;

    assign res_valid   = res_valid_reg;
    assign plain_block = plain_reg;
    assign status.busy = (state_reg == ST_RUN);
    assign status.pop  = pop;

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        blk_next       = blk_reg;
        plain_next     = plain_reg;
        res_valid_next = res_valid_reg && !res_ready;
        rd_addr        = AW'(KEY_SLOTS - 1);
        mem_we         = 1'b0;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (q_item.action == ACT_LOAD_KEY)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        blk_next   = q_item.data;
                        round_next = AW'(KEY_SLOTS - 1);
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (round_reg != '0)
                begin
                    rd_addr    = round_reg - 1'b1;
                    blk_next   = inv_sbox_layer(inv_perm(blk_reg ^ key_rd));
                    round_next = round_reg - 1'b1;
                end
                else
                begin
                    rd_addr = '0;
                    if (!res_valid_reg || res_ready)
                    begin
                        plain_next     = blk_reg ^ key_rd;
                        res_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg   <= blk_next;
        plain_reg <= plain_next;
    end

    // Round key RAM, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[q_item.slot[AW-1:0]] <= q_item.data;
        end
        key_rd <= key_mem[rd_addr];
    end

endmodule
